/* hdl/pvc_program_rom_descramble_core_defines.svh */
// assertion macros used by the descrambler back end
`ifndef PVC_PROGRAM_ROM_DESCRAMBLE_CORE_DEFINES_SVH
`define PVC_PROGRAM_ROM_DESCRAMBLE_CORE_DEFINES_SVH

// same-cycle implication
`define PVCRD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PVCRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/pvcrd_pkg.sv */
package pvcrd_pkg;

   localparam int unsigned IMAGE_BYTES = 9437184;
   localparam int unsigned ADDR_W = 24;
   localparam logic [ADDR_W-1:0] IMAGE_LIMIT = ADDR_W'(IMAGE_BYTES);
   localparam logic [ADDR_W-1:0] REGION_BYTES = 24'h100000;
   localparam logic [ADDR_W-1:0] TOP_BASE = 24'h800000;
   localparam logic [ADDR_W-1:0] PARTNER_BASE = 24'h100002;
   localparam logic [ADDR_W-1:0] BLOCK_BYTES = 24'h010000;
   localparam logic [ADDR_W-1:0] NIBBLE_FLIP_REG = 24'h000800;
   localparam logic [ADDR_W-1:0] NIBBLE_FLIP_HOME = 24'h000400;

   localparam logic [7:0] PAD_LOW [32] = '{
      8'h3b, 8'h6a, 8'hf7, 8'hb7, 8'he8, 8'ha9, 8'h20, 8'h99, 8'h9f, 8'h39, 8'h34, 8'h0c,
      8'hc3, 8'h9a, 8'ha5, 8'hc8, 8'hb8, 8'h18, 8'hce, 8'h56, 8'h94, 8'h44, 8'he3, 8'h7a,
      8'hf7, 8'hdd, 8'h42, 8'hf0, 8'h18, 8'h60, 8'h92, 8'h9f};
   localparam logic [7:0] PAD_MID_REG [32] = '{
      8'h2f, 8'h02, 8'h60, 8'hbb, 8'h77, 8'h01, 8'h30, 8'h08, 8'hd8, 8'h01, 8'ha0, 8'hdf,
      8'h37, 8'h0a, 8'hf0, 8'h65, 8'h28, 8'h03, 8'hd0, 8'h23, 8'hd3, 8'h03, 8'h70, 8'h42,
      8'hbb, 8'h06, 8'hf0, 8'h28, 8'hba, 8'h0f, 8'hf0, 8'h7a};
   localparam logic [7:0] PAD_MID_HOME [32] = '{
      8'h2b, 8'h09, 8'hd0, 8'h7f, 8'h51, 8'h0b, 8'h10, 8'h4c, 8'h5b, 8'h07, 8'h70, 8'h9d,
      8'h3e, 8'h0b, 8'hb0, 8'hb6, 8'h54, 8'h09, 8'he0, 8'hcc, 8'h3d, 8'h0d, 8'h80, 8'h99,
      8'h87, 8'h03, 8'h90, 8'h82, 8'hfe, 8'h04, 8'h20, 8'h18};

   typedef enum logic [2:0] {
      OP_LOAD,
      OP_ZERO,
      OP_SINGLE,
      OP_PARTNER,
      OP_SWAP
   } pvcrd_op_type;

   typedef struct packed {
      pvcrd_op_type      op;
      logic [ADDR_W-1:0] addr0;
      logic [ADDR_W-1:0] addr1;
      logic [7:0]        pad0;
      logic [7:0]        pad1;
      logic [7:0]        load_data;
      logic              hi_sel;
      logic              home;
   } pvcrd_entry_type;

   function automatic logic [7:0] mid_pad(input logic [ADDR_W-1:0] addr, input logic home);
      logic [4:0] k;
      k = addr[4:0] ^ 5'd1;
      return home ? PAD_MID_HOME[k] : PAD_MID_REG[k];
   endfunction

   function automatic logic [15:0] swap_word(input logic [15:0] w, input logic home);
      logic [15:0] r;
      r = w & 16'hf00f;
      if (home) begin
         r[11] = w[10]; r[10] = w[11]; r[9] = w[8]; r[8] = w[9];
         r[7]  = w[6];  r[6]  = w[7];  r[5] = w[4]; r[4] = w[5];
      end else begin
         r[11] = w[5];  r[10] = w[4];  r[9] = w[7]; r[8] = w[6];
         r[7]  = w[9];  r[6]  = w[8];  r[5] = w[11]; r[4] = w[10];
      end
      return r;
   endfunction

endpackage

/* hdl/pvcrd_front.sv */
module pvcrd_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_mode,
   input  logic [23:0]             req_address,
   input  logic [7:0]              req_load_byte,
   input  logic                    csr_wr_en,
   input  logic                    csr_wr_data,
   input  logic                    q_full,
   output logic                    q_push,
   output pvcrd_pkg::pvcrd_entry_type q_entry
);
   import pvcrd_pkg::*;

   logic home_ff, home_in;

   always_comb begin
      home_in = csr_wr_en ? csr_wr_data : home_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         home_ff <= 1'b0;
      end else begin
         home_ff <= home_in;
      end
   end

   always_comb begin
      logic              in_range;
      logic [3:0]        blk;
      logic [3:0]        nb;
      logic [ADDR_W-1:0] b;
      logic [7:0]        m;
      logic [7:0]        nm;
      logic [ADDR_W-1:0] flip;
      logic [ADDR_W-1:0] s;
      logic [ADDR_W-1:0] g;

      in_range = req_address < IMAGE_LIMIT;
      blk = req_address[19:16];
      nb = {home_ff ? blk[1] : blk[0], home_ff ? blk[0] : blk[1], blk[2], blk[3]};
      if (req_address[23:20] == 4'h1) begin
         b = req_address + (TOP_BASE - REGION_BYTES);
      end else begin
         b = req_address - REGION_BYTES;
      end
      m = b[19:12];
      if (home_ff) begin
         nm = {m[6], m[7], m[4], m[5], m[0], m[1], m[3], m[2]};
      end else begin
         nm = {m[4], m[5], m[6], m[7], m[1], m[0], m[3], m[2]};
      end
      flip = home_ff ? NIBBLE_FLIP_HOME : NIBBLE_FLIP_REG;
      if (req_address < REGION_BYTES) begin
         s = {4'h0, nb, 16'h0000} | (req_address & (BLOCK_BYTES - 24'd1));
      end else begin
         s = (b & 24'hf000ff) | ((b & 24'h000f00) ^ flip) | {4'h0, nm, 12'h000};
      end
      g = {s[23:2], 2'b00};

      q_entry = '0;
      q_entry.home = home_ff;
      q_entry.load_data = req_load_byte;
      q_entry.addr0 = s;
      priority if (!req_mode) begin
         q_entry.op = OP_LOAD;
         q_entry.addr0 = req_address;
      end else if (!in_range) begin
         q_entry.op = OP_ZERO;
         q_entry.addr0 = '0;
      end else if (s < REGION_BYTES) begin
         q_entry.op = OP_SINGLE;
         q_entry.pad0 = PAD_LOW[s[4:0] ^ 5'd1];
      end else if (s >= TOP_BASE) begin
         q_entry.op = OP_PARTNER;
         q_entry.addr1 = PARTNER_BASE | (s & (REGION_BYTES - 24'd1));
      end else if (s[1:0] == 2'd1 || s[1:0] == 2'd2) begin
         q_entry.op = OP_SINGLE;
         q_entry.pad0 = mid_pad(s, home_ff);
      end else begin
         q_entry.op = OP_SWAP;
         q_entry.addr0 = g;
         q_entry.addr1 = g | 24'd3;
         q_entry.pad0 = mid_pad(g, home_ff);
         q_entry.pad1 = mid_pad(g | 24'd3, home_ff);
         q_entry.hi_sel = s[1:0] == 2'd3;
      end

      req_ready = !q_full;
      // loads beyond the image are dropped here
      q_push = req_valid && req_ready && (req_mode || in_range);
   end

endmodule

/* hdl/pvcrd_queue.sv */
module pvcrd_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  pvcrd_pkg::pvcrd_entry_type push_entry,
   input  logic                       pop,
   output logic                       full,
   output logic                       head_valid,
   output pvcrd_pkg::pvcrd_entry_type head
);
   import pvcrd_pkg::*;

   pvcrd_entry_type slot_ff [2];
   logic            wr_ptr_ff, wr_ptr_in;
   logic            rd_ptr_ff, rd_ptr_in;
   logic [1:0]      count_ff, count_in;

   always_comb begin
      full = count_ff == 2'd2;
      head_valid = count_ff != 2'd0;
      head = slot_ff[rd_ptr_ff];
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

/* hdl/pvcrd_back.sv */
module pvcrd_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_valid,
   input  pvcrd_pkg::pvcrd_entry_type q_head,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [7:0]                 rsp_plain_byte
);
   import pvcrd_pkg::*;
   `include "pvc_program_rom_descramble_core_defines.svh"

   logic [7:0]        image_ff [IMAGE_BYTES];
   logic [7:0]        rdata_ff;
   logic [7:0]        hold_ff;
   logic              phase_ff, phase_in;
   logic              d_valid_ff, d_valid_in;
   pvcrd_entry_type   d_ctx_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_addr;
   logic              credit;
   logic              two_access;
   logic [7:0]        result;
   logic [7:0]        out_ff [2];
   logic              out_wr_ff, out_wr_in;
   logic              out_rd_ff, out_rd_in;
   logic [1:0]        out_cnt_ff, out_cnt_in;
   logic              out_pop;

   // issue side: one memory access per cycle
   always_comb begin
      two_access = q_head.op == OP_PARTNER || q_head.op == OP_SWAP;
      credit = (out_cnt_ff + {1'b0, d_valid_ff}) < 2'd2;
      q_pop = 1'b0;
      mem_we = 1'b0;
      mem_addr = q_head.addr0;
      phase_in = phase_ff;
      d_valid_in = 1'b0;
      priority if (!q_valid) begin
         phase_in = phase_ff;
      end else if (phase_ff) begin
         mem_addr = q_head.addr1;
         q_pop = 1'b1;
         phase_in = 1'b0;
         d_valid_in = 1'b1;
      end else if (q_head.op == OP_LOAD) begin
         mem_we = 1'b1;
         q_pop = 1'b1;
      end else if (credit) begin
         if (two_access) begin
            phase_in = 1'b1;
         end else begin
            q_pop = 1'b1;
            d_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         image_ff[mem_addr] <= q_head.load_data;
      end else begin
         rdata_ff <= image_ff[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (phase_ff) begin
         hold_ff <= rdata_ff;
      end
      if (d_valid_in) begin
         d_ctx_ff <= q_head;
      end
   end

   // data side: combine fetched bytes
   always_comb begin
      logic [15:0] w;
      w = swap_word({rdata_ff ^ d_ctx_ff.pad1, hold_ff ^ d_ctx_ff.pad0}, d_ctx_ff.home);
      unique case (d_ctx_ff.op)
         OP_SINGLE:  result = rdata_ff ^ d_ctx_ff.pad0;
         OP_PARTNER: result = hold_ff ^ rdata_ff;
         OP_SWAP:    result = d_ctx_ff.hi_sel ? w[15:8] : w[7:0];
         default:    result = 8'h00;
      endcase
   end

   always_comb begin
      rsp_valid = out_cnt_ff != 2'd0;
      out_pop = rsp_valid && rsp_ready;
      rsp_plain_byte = out_ff[out_rd_ff];
      out_wr_in = d_valid_ff ? !out_wr_ff : out_wr_ff;
      out_rd_in = out_pop ? !out_rd_ff : out_rd_ff;
      out_cnt_in = out_cnt_ff + {1'b0, d_valid_ff} - {1'b0, out_pop};
   end

   always_ff @(posedge clock) begin
      if (d_valid_ff) begin
         out_ff[out_wr_ff] <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         out_wr_ff <= 1'b0;
         out_rd_ff <= 1'b0;
         out_cnt_ff <= 2'd0;
      end else begin
         phase_ff <= phase_in;
         d_valid_ff <= d_valid_in;
         out_wr_ff <= out_wr_in;
         out_rd_ff <= out_rd_in;
         out_cnt_ff <= out_cnt_in;
      end
   end

   `PVCRD_ASSERT_NOW(a_second_has_head, clock, reset, phase_ff, q_valid, "second access without queued word")
   `PVCRD_ASSERT_NEXT(a_second_one_cycle, clock, reset, phase_ff, !phase_ff && d_valid_ff, "second access did not finish")
   `PVCRD_ASSERT_NOW(a_result_has_room, clock, reset, d_valid_ff, out_cnt_ff != 2'd2, "result queue overflow")
   `PVCRD_ASSERT_NOW(a_no_write_mid_read, clock, reset, phase_ff, !mem_we, "write during paired read")

endmodule

/* hdl/pvc_program_rom_descramble_core.sv */
// channel   direction  handshake              word
// req       in         req_valid/req_ready    req_mode, req_address, req_load_byte
// rsp       out        rsp_valid/rsp_ready    rsp_plain_byte
// csr       in         csr_wr_en              csr_wr_data (variant select)
//
// loads and single-access reads take one access of the single image memory port, partner
// and bit swap reads two; read issue waits for result queue room, counting the read in flight
// a read byte is registered in the memory read register, then in the result queue
// reset clears control and the variant select; the image is undefined until loaded
// a two-deep word queue parts the front from the memory side; a two-deep result
// queue absorbs short rsp stalls, longer ones back up into req

module pvc_program_rom_descramble_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [23:0] req_address,
   input  logic [7:0]  req_load_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_plain_byte,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);
   import pvcrd_pkg::*;

   logic            q_full;
   logic            q_push;
   logic            q_pop;
   logic            q_valid;
   pvcrd_entry_type q_entry;
   pvcrd_entry_type q_head;

   pvcrd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_address   (req_address),
      .req_load_byte (req_load_byte),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_entry       (q_entry)
   );

   pvcrd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_valid),
      .head       (q_head)
   );

   pvcrd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_plain_byte (rsp_plain_byte)
   );

endmodule
